### rtl/core/srde_pkg.sv
// Shared types, constants and the sequencer program of the radix digit emitter.
// Holds no logic of its own; every other file takes names from it by scope.

package srde_pkg;

  localparam int SYM_W   = 8;
  localparam int LEN_W   = 5;
  localparam int DATA_W  = 64;
  localparam int INDEX_W = 2;
  localparam int STEP_W  = 4;

  // Sign and reserved symbol bytes
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_NUL   = 8'h00;

  // Reset contents: radix ten, symbols "0123456709" (slot 8 repeats the 0)
  localparam logic [LEN_W-1:0]  BASE_LENGTH_RESET  = 5'd10;
  localparam logic [DATA_W-1:0] SYMBOLS_LOW_RESET  = 64'h3736_3534_3332_3130;
  localparam logic [DATA_W-1:0] SYMBOLS_HIGH_RESET = 64'h0000_0000_0000_3930;

  typedef enum logic [INDEX_W-1:0] {
    REG_BASE_LENGTH  = 2'd0,
    REG_SYMBOLS_LOW  = 2'd1,
    REG_SYMBOLS_HIGH = 2'd2
  } reg_index_t;

  typedef logic [STEP_W-1:0] step_t;

  // Program addresses
  localparam step_t STEP_IDLE       = 4'd0;
  localparam step_t STEP_CHECK      = 4'd1;
  localparam step_t STEP_ZERO_TEST  = 4'd2;
  localparam step_t STEP_EMIT_ZERO  = 4'd3;
  localparam step_t STEP_DIV_INIT   = 4'd4;
  localparam step_t STEP_DIV_STEP   = 4'd5;
  localparam step_t STEP_DIV_STORE  = 4'd6;
  localparam step_t STEP_SIGN_TEST  = 4'd7;
  localparam step_t STEP_EMIT_MINUS = 4'd8;
  localparam step_t STEP_READ       = 4'd9;
  localparam step_t STEP_EMIT_DIGIT = 4'd10;
  localparam step_t STEP_DONE       = 4'd11;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_DIV_INIT,
    ACT_DIV_STEP,
    ACT_STORE,
    ACT_EMIT_ZERO,
    ACT_EMIT_MINUS,
    ACT_READ,
    ACT_EMIT_DIGIT
  } act_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_BASE_BAD,
    COND_VALUE_NZ,
    COND_CHUNK_MORE,
    COND_MORE_DIGITS,
    COND_POSITIVE,
    COND_COUNT_NZ
  } cond_t;

  // One control word: action, hold while the output register is full,
  // jump condition and jump target (fall through to the next step otherwise)
  typedef struct packed {
    act_t  act;
    logic  wait_out;
    cond_t cond;
    step_t target;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t pc);
    ctrl_t w;
    w = '{act: ACT_NONE, wait_out: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
    case (pc)
      STEP_IDLE:       w = '{ACT_LOAD,       1'b0, COND_NO_INPUT,    STEP_IDLE};
      STEP_CHECK:      w = '{ACT_NONE,       1'b0, COND_BASE_BAD,    STEP_IDLE};
      STEP_ZERO_TEST:  w = '{ACT_NONE,       1'b0, COND_VALUE_NZ,    STEP_DIV_INIT};
      STEP_EMIT_ZERO:  w = '{ACT_EMIT_ZERO,  1'b1, COND_ALWAYS,      STEP_IDLE};
      STEP_DIV_INIT:   w = '{ACT_DIV_INIT,   1'b0, COND_NEVER,       STEP_IDLE};
      STEP_DIV_STEP:   w = '{ACT_DIV_STEP,   1'b0, COND_CHUNK_MORE,  STEP_DIV_STEP};
      STEP_DIV_STORE:  w = '{ACT_STORE,      1'b0, COND_MORE_DIGITS, STEP_DIV_INIT};
      STEP_SIGN_TEST:  w = '{ACT_NONE,       1'b0, COND_POSITIVE,    STEP_READ};
      STEP_EMIT_MINUS: w = '{ACT_EMIT_MINUS, 1'b1, COND_NEVER,       STEP_IDLE};
      STEP_READ:       w = '{ACT_READ,       1'b0, COND_NEVER,       STEP_IDLE};
      STEP_EMIT_DIGIT: w = '{ACT_EMIT_DIGIT, 1'b1, COND_COUNT_NZ,    STEP_READ};
      STEP_DONE:       w = '{ACT_NONE,       1'b0, COND_ALWAYS,      STEP_IDLE};
      default:         w = '{ACT_NONE,       1'b0, COND_ALWAYS,      STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/srde_if.sv
// Valid/ready channels of the radix digit emitter: numbers in, symbols out.
// Depends on srde_pkg for the symbol width.

interface srde_number_if #(parameter int WIDTH = 32);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface srde_symbol_if;
  logic                         valid;
  logic                         ready;
  logic [srde_pkg::SYM_W-1:0]   symbol;
  logic                         last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

### rtl/core/signed_radix_digit_emitter.sv
// Signed integer to symbol string converter for a configurable radix.
// Depends on srde_pkg and the channel interfaces in srde_if.sv.
//
// Usage: numbers (sink) takes one signed value per transaction; symbols
// (source) returns its text, most significant symbol first, '-' leading for
// negatives, last high on the final symbol. Zero gives symbol 0 alone. An
// invalid base (length below 2, or an active symbol that is '+', '-', a zero
// byte or a repeat) drops the number with no output.
// The configuration port writes base_length (saturates at MAX_BASE),
// symbols_low and symbols_high; write it only while the block is idle.
// Operation: a microcoded sequencer runs the work. It accepts the number,
// checks the base and tests for zero; for each digit the divider, which
// retires 8 quotient bits a cycle (CHUNKS = ceil(NUMBER_WIDTH / 8), 4 at 32
// bits), works through the chunks and stores the remainder; the sign test
// follows and emits '-' for negatives; each digit is then read from the
// digit memory and emitted, and a last step ends the run. One number is in
// work at a time.
// Reset: a synchronous rst returns the sequencer to idle, empties the output
// register and restores the reset configuration. A stalled receiver holds the
// sequencer at its emit step; the output register holds its transaction.

module signed_radix_digit_emitter #(
  parameter int MAX_BASE     = 16,
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             write_enable,
  input  logic [srde_pkg::INDEX_W-1:0]     write_index,
  input  logic [srde_pkg::DATA_W-1:0]      write_data,
  srde_number_if.sink                      numbers,
  srde_symbol_if.source                    symbols
);

  localparam int DIG_W      = $clog2(MAX_BASE);
  localparam int DIV_W      = DIG_W + 1;
  localparam int CNT_W      = $clog2(NUMBER_WIDTH + 1);
  localparam int IDX_W      = $clog2(NUMBER_WIDTH);
  localparam int STEP_BITS  = 8;
  localparam int CHUNKS     = (NUMBER_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int CHUNK_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int LEN_RESET  = (srde_pkg::BASE_LENGTH_RESET > MAX_BASE) ?
                              MAX_BASE : srde_pkg::BASE_LENGTH_RESET;

  // Configuration registers
  logic [srde_pkg::LEN_W-1:0]  base_length;
  logic [srde_pkg::DATA_W-1:0] symbols_low;
  logic [srde_pkg::DATA_W-1:0] symbols_high;
  logic [srde_pkg::LEN_W-1:0]  len_in;

  // Sequencer and datapath
  srde_pkg::step_t             pc;
  srde_pkg::step_t             pc_next;
  srde_pkg::ctrl_t             ctrl;
  logic                        cond_hit;
  logic                        stall;
  logic                        act_en;

  logic [NUMBER_WIDTH-1:0]     value;
  logic [NUMBER_WIDTH-1:0]     num_bits;
  logic                        neg;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_dec;
  logic [DIG_W-1:0]            rem;
  logic [CHUNK_W-1:0]          chunk;
  logic [DIV_W-1:0]            divisor;
  logic [NUMBER_WIDTH-1:0]     quot_next;
  logic [DIG_W-1:0]            rem_next;

  logic [DIG_W-1:0]            digit_store [NUMBER_WIDTH];
  logic [DIG_W-1:0]            rd_data;

  logic [srde_pkg::SYM_W-1:0]  sym [16];
  logic                        base_bad;

  logic                        out_valid;
  logic [srde_pkg::SYM_W-1:0]  out_symbol;
  logic                        out_last;

  // ---------------------------------------------------------------------------
  // Configuration: saturate the length, ignore indexes beyond the list
  // ---------------------------------------------------------------------------
  assign len_in = write_data[srde_pkg::LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length  <= srde_pkg::LEN_W'(LEN_RESET);
      symbols_low  <= srde_pkg::SYMBOLS_LOW_RESET;
      symbols_high <= srde_pkg::SYMBOLS_HIGH_RESET;
    end else if (write_enable) begin
      case (srde_pkg::reg_index_t'(write_index))
        srde_pkg::REG_BASE_LENGTH: begin
          base_length <= (len_in > srde_pkg::LEN_W'(MAX_BASE)) ?
                         srde_pkg::LEN_W'(MAX_BASE) : len_in;
        end
        srde_pkg::REG_SYMBOLS_LOW:  symbols_low  <= write_data;
        srde_pkg::REG_SYMBOLS_HIGH: symbols_high <= write_data;
        default: ;
      endcase
    end
  end

  // Unpack the symbol table
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sym[i]     = symbols_low[8*i +: 8];
      sym[i + 8] = symbols_high[8*i +: 8];
    end
  end

  // Base check: length at least 2, every active symbol legal and distinct
  always_comb begin
    base_bad = (base_length < srde_pkg::LEN_W'(2));
    for (int i = 0; i < MAX_BASE; i++) begin
      if (srde_pkg::LEN_W'(i) < base_length) begin
        if (sym[i] == srde_pkg::SYM_PLUS || sym[i] == srde_pkg::SYM_MINUS ||
            sym[i] == srde_pkg::SYM_NUL) begin
          base_bad = 1'b1;
        end
        for (int j = i + 1; j < MAX_BASE; j++) begin
          if (srde_pkg::LEN_W'(j) < base_length && sym[i] == sym[j]) begin
            base_bad = 1'b1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: fetch the control word, resolve the jump, hold on a full output
  // ---------------------------------------------------------------------------
  assign ctrl      = srde_pkg::ucode(pc);
  assign stall     = ctrl.wait_out && out_valid && !symbols.ready;
  assign act_en    = !stall;
  assign count_dec = count - CNT_W'(1);
  assign divisor   = base_length[DIV_W-1:0];
  assign num_bits  = NUMBER_WIDTH'(numbers.number);

  always_comb begin
    case (ctrl.cond)
      srde_pkg::COND_NEVER:       cond_hit = 1'b0;
      srde_pkg::COND_ALWAYS:      cond_hit = 1'b1;
      srde_pkg::COND_NO_INPUT:    cond_hit = !numbers.valid;
      srde_pkg::COND_BASE_BAD:    cond_hit = base_bad;
      srde_pkg::COND_VALUE_NZ:    cond_hit = (value != '0);
      srde_pkg::COND_CHUNK_MORE:  cond_hit = (chunk != CHUNK_W'(CHUNKS - 1));
      srde_pkg::COND_MORE_DIGITS: begin
        cond_hit = (value != '0) && (count < CNT_W'(NUMBER_WIDTH - 1));
      end
      srde_pkg::COND_POSITIVE:    cond_hit = !neg;
      srde_pkg::COND_COUNT_NZ:    cond_hit = (count != '0);
      default:                    cond_hit = 1'b0;
    endcase

    if (stall) begin
      pc_next = pc;
    end else if (cond_hit) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + srde_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= srde_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign numbers.ready = (pc == srde_pkg::STEP_IDLE);

  // ---------------------------------------------------------------------------
  // Divider: eight restoring steps a cycle, quotient shifts into value
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [DIV_W-1:0] trial;
    quot_next = value;
    rem_next  = rem;
    trial     = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      if (int'(chunk) * STEP_BITS + i < NUMBER_WIDTH) begin
        trial     = {rem_next, quot_next[NUMBER_WIDTH-1]};
        quot_next = {quot_next[NUMBER_WIDTH-2:0], 1'b0};
        if (trial >= divisor) begin
          trial        = trial - divisor;
          quot_next[0] = 1'b1;
        end
        rem_next = trial[DIG_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath actions
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      count <= '0;
      neg   <= 1'b0;
    end else if (act_en) begin
      case (ctrl.act)
        srde_pkg::ACT_LOAD: begin
          if (numbers.valid) begin
            // Magnitude wraps for the most negative value, which is still right
            value <= num_bits[NUMBER_WIDTH-1] ? (~num_bits + NUMBER_WIDTH'(1)) : num_bits;
            neg   <= num_bits[NUMBER_WIDTH-1];
            count <= '0;
          end
        end
        srde_pkg::ACT_DIV_STEP: value <= quot_next;
        srde_pkg::ACT_STORE:    count <= count + CNT_W'(1);
        srde_pkg::ACT_READ:     count <= count_dec;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.act)
      srde_pkg::ACT_DIV_INIT: begin
        rem   <= '0;
        chunk <= '0;
      end
      srde_pkg::ACT_DIV_STEP: begin
        rem   <= rem_next;
        chunk <= chunk + CHUNK_W'(1);
      end
      default: ;
    endcase
  end

  // Digit memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (ctrl.act == srde_pkg::ACT_STORE) begin
      digit_store[count[IDX_W-1:0]] <= rem;
    end
    if (ctrl.act == srde_pkg::ACT_READ) begin
      rd_data <= digit_store[count_dec[IDX_W-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: load on an emit step, drop when the receiver takes it
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (act_en && (ctrl.act == srde_pkg::ACT_EMIT_ZERO ||
                            ctrl.act == srde_pkg::ACT_EMIT_MINUS ||
                            ctrl.act == srde_pkg::ACT_EMIT_DIGIT)) begin
      out_valid <= 1'b1;
    end else if (symbols.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act_en) begin
      case (ctrl.act)
        srde_pkg::ACT_EMIT_ZERO: begin
          out_symbol <= sym[0];
          out_last   <= 1'b1;
        end
        srde_pkg::ACT_EMIT_MINUS: begin
          out_symbol <= srde_pkg::SYM_MINUS;
          out_last   <= 1'b0;
        end
        srde_pkg::ACT_EMIT_DIGIT: begin
          out_symbol <= sym[4'(rd_data)];
          out_last   <= (count == '0);
        end
        default: ;
      endcase
    end
  end

  assign symbols.valid  = out_valid;
  assign symbols.symbol = out_symbol;
  assign symbols.last   = out_last;

`ifndef SYNTHESIS
  a_len_saturated: assert property (@(posedge clk) disable iff (rst)
    base_length <= srde_pkg::LEN_W'(MAX_BASE))
    else $error("base_length above MAX_BASE");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUMBER_WIDTH))
    else $error("digit count beyond number width");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    (pc == srde_pkg::STEP_DIV_STORE) |-> ({1'b0, rem} < divisor))
    else $error("remainder not below radix");

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (numbers.valid && numbers.ready) |=> (pc == srde_pkg::STEP_CHECK))
    else $error("accepted number did not start the base check");
`endif

endmodule

### bench/radix_text_checker.sv
// Self-contained checker for the radix digit emitter: follows configuration writes, predicts
// the symbol run of every accepted number and compares it with the symbol channel.
// Depends on srde_pkg and the channel interfaces of srde_if.sv.

module radix_text_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         write_enable,
  input  logic [srde_pkg::INDEX_W-1:0] write_index,
  input  logic [srde_pkg::DATA_W-1:0]  write_data,
  srde_number_if                       numbers,
  srde_symbol_if                       symbols,
  output int                           mismatches,
  output int                           outstanding
);

  localparam int MAX_RADIX = 16;

  typedef struct packed {
    logic [srde_pkg::SYM_W-1:0] symbol;
    logic                       last;
  } glyph_t;

  logic [srde_pkg::LEN_W-1:0]  radix;
  logic [srde_pkg::DATA_W-1:0] alphabet_low;
  logic [srde_pkg::DATA_W-1:0] alphabet_high;
  glyph_t                      expected_text[$];

  function automatic logic [srde_pkg::SYM_W-1:0] glyph_at(input int slot);
    logic [2*srde_pkg::DATA_W-1:0] alphabet;
    alphabet = {alphabet_high, alphabet_low};
    return alphabet[8*slot +: 8];
  endfunction

  function automatic bit alphabet_usable();
    logic [srde_pkg::SYM_W-1:0] glyph;
    if (radix < 2) return 1'b0;
    for (int i = 0; i < radix; i++) begin
      glyph = glyph_at(i);
      if (glyph == srde_pkg::SYM_PLUS || glyph == srde_pkg::SYM_MINUS ||
          glyph == srde_pkg::SYM_NUL) return 1'b0;
      for (int j = i + 1; j < radix; j++) begin
        if (glyph_at(j) == glyph) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Queue the text of one number: sign first, then digits from the most significant
  function automatic void spell_number(input logic signed [31:0] value);
    logic [31:0] magnitude;
    logic [3:0]  digits[32];
    int          count;
    if (!alphabet_usable()) return;
    if (value == 0) begin
      expected_text.push_back('{glyph_at(0), 1'b1});
      return;
    end
    magnitude = value[31] ? (~value + 32'd1) : value;
    count = 0;
    while (magnitude != 0) begin
      digits[count] = 4'(magnitude % radix);
      magnitude = magnitude / radix;
      count++;
    end
    if (value[31]) expected_text.push_back('{srde_pkg::SYM_MINUS, 1'b0});
    for (int k = count - 1; k >= 0; k--) begin
      expected_text.push_back('{glyph_at(digits[k]), k == 0});
    end
  endfunction

  always @(posedge clk) begin
    glyph_t want;
    if (rst) begin
      radix = srde_pkg::BASE_LENGTH_RESET;
      alphabet_low = srde_pkg::SYMBOLS_LOW_RESET;
      alphabet_high = srde_pkg::SYMBOLS_HIGH_RESET;
      expected_text.delete();
      mismatches = 0;
    end else begin
      if (write_enable) begin
        case (write_index)
          srde_pkg::REG_BASE_LENGTH: begin
            radix = (write_data[srde_pkg::LEN_W-1:0] > MAX_RADIX) ?
                    srde_pkg::LEN_W'(MAX_RADIX) : write_data[srde_pkg::LEN_W-1:0];
          end
          srde_pkg::REG_SYMBOLS_LOW: begin
            alphabet_low = write_data;
          end
          srde_pkg::REG_SYMBOLS_HIGH: begin
            alphabet_high = write_data;
          end
          default: begin
          end
        endcase
      end
      // Retire the oldest expectation before queueing new ones
      if (symbols.valid && symbols.ready) begin
        if (expected_text.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected symbol: expected none, actual %h last %b",
                   $time, symbols.symbol, symbols.last);
        end else begin
          want = expected_text.pop_front();
          if (symbols.symbol !== want.symbol) begin
            mismatches++;
            $display("%0t: symbol: expected %h, actual %h", $time, want.symbol, symbols.symbol);
          end
          if (symbols.last !== want.last) begin
            mismatches++;
            $display("%0t: last: expected %b, actual %b", $time, want.last, symbols.last);
          end
        end
      end
      if (numbers.valid && numbers.ready) spell_number(numbers.number);
    end
    outstanding = expected_text.size();
  end

endmodule

### bench/testbench.sv
// Top of the radix digit emitter bench: clock, reset, configuration writes and number
// stimulus with random idling; the checker beside the block gives the failure count.
// Depends on srde_pkg, srde_if.sv, the emitter and radix_text_checker.

module testbench;

  // Index with no register behind it; writes there must change nothing
  localparam logic [srde_pkg::INDEX_W-1:0] REG_UNMAPPED = 2'd3;

  localparam logic signed [31:0] NUM_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] NUM_MAX = 32'sh7FFF_FFFF;

  // "0123456789ABCDEF", symbol 0 in the lowest byte
  localparam logic [2*srde_pkg::DATA_W-1:0] HEX_DIGITS =
    {64'h4645_4443_4241_3938, 64'h3736_3534_3332_3130};

  // Settle time covers a base-2 number of 32 digits in the sequencer
  localparam int SETTLE_CYCLES    = 300;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int WATCHDOG_LIMIT   = 5000;

  logic                         clk;
  logic                         rst;
  logic                         write_enable;
  logic [srde_pkg::INDEX_W-1:0] write_index;
  logic [srde_pkg::DATA_W-1:0]  write_data;

  int mismatches;
  int outstanding;
  int send_idle_pct;
  int stall_pct;
  int quiet_cycles;
  bit long_hold_req;
  bit long_hold_served;

  srde_number_if #(.WIDTH(32)) number_ch ();
  srde_symbol_if               symbol_ch ();

  signed_radix_digit_emitter #(
    .MAX_BASE     (16),
    .NUMBER_WIDTH (32)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .numbers      (number_ch),
    .symbols      (symbol_ch)
  );

  radix_text_checker text_check (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .numbers      (number_ch),
    .symbols      (symbol_ch),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls at the rate of the current phase, plus one long hold-off
  // counted here so that the block fills up while numbers keep arriving.
  initial begin
    symbol_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        symbol_ch.ready <= 1'b0;
      end else if (long_hold_req && !long_hold_served) begin
        symbol_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_served = 1'b1;
      end else begin
        symbol_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: abandon the run once nothing has moved for too long
  always @(posedge clk) begin
    if (rst || write_enable || (number_ch.valid && number_ch.ready) ||
        (symbol_ch.valid && symbol_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one number, idling first at the current sender rate; return at the accepting edge
  task automatic offer_number(input logic signed [31:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      number_ch.valid <= 1'b0;
      @(posedge clk);
    end
    number_ch.valid  <= 1'b1;
    number_ch.number <= value;
    @(posedge clk);
    while (!number_ch.ready) @(posedge clk);
  endtask

  // Stop sending, wait for every expected symbol, then let a number with no output finish
  task automatic await_quiet();
    number_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers, the unmapped index first; call only while the block is idle
  task automatic load_base(input logic [srde_pkg::DATA_W-1:0] length_word,
                           input logic [2*srde_pkg::DATA_W-1:0] alphabet);
    write_enable <= 1'b1;
    write_index  <= REG_UNMAPPED;
    write_data   <= {$urandom, $urandom};
    @(posedge clk);
    write_index  <= srde_pkg::REG_BASE_LENGTH;
    write_data   <= length_word;
    @(posedge clk);
    write_index  <= srde_pkg::REG_SYMBOLS_LOW;
    write_data   <= alphabet[srde_pkg::DATA_W-1:0];
    @(posedge clk);
    write_index  <= srde_pkg::REG_SYMBOLS_HIGH;
    write_data   <= alphabet[2*srde_pkg::DATA_W-1:srde_pkg::DATA_W];
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  // Distinct usable symbols in the active slots; anything at all above them
  function automatic logic [2*srde_pkg::DATA_W-1:0] draw_alphabet(input int active);
    logic [2*srde_pkg::DATA_W-1:0] bits;
    logic [srde_pkg::SYM_W-1:0]    glyph;
    bit                            clash;
    bits = '0;
    for (int i = 0; i < 16; i++) begin
      if (i >= active) begin
        glyph = srde_pkg::SYM_W'($urandom);
      end else begin
        do begin
          glyph = srde_pkg::SYM_W'($urandom_range(1, 255));
          clash = (glyph == srde_pkg::SYM_PLUS) || (glyph == srde_pkg::SYM_MINUS);
          for (int j = 0; j < i; j++) begin
            if (bits[8*j +: 8] == glyph) clash = 1'b1;
          end
        end while (clash);
      end
      bits[8*i +: 8] = glyph;
    end
    return bits;
  endfunction

  // Mix of full-range values, values near zero, extremes and assorted magnitudes
  function automatic logic signed [31:0] pick_number();
    logic signed [31:0] value;
    int                 pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      value = $urandom_range(0, 40) - 20;
    end else if (pick == 1) begin
      case ($urandom_range(0, 3))
        0: value = NUM_MIN;
        1: value = NUM_MAX;
        2: value = -1;
        default: value = 1;
      endcase
    end else if (pick < 5) begin
      value = $signed($urandom) >>> $urandom_range(0, 31);
    end else begin
      value = $urandom;
    end
    return value;
  endfunction

  initial begin
    logic [2*srde_pkg::DATA_W-1:0] alphabet;
    logic [srde_pkg::DATA_W-1:0]   length_word;
    int                            radix;
    int                            slot;
    int                            other;
    bit                            flawed;

    rst              <= 1'b1;
    write_enable     <= 1'b0;
    write_index      <= srde_pkg::REG_BASE_LENGTH;
    write_data       <= '0;
    number_ch.valid  <= 1'b0;
    number_ch.number <= '0;
    stall_pct        <= 0;
    long_hold_req    <= 1'b0;
    long_hold_served = 1'b0;
    send_idle_pct    = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset base, whose slot 8 repeats '0' and so drops every number: zero, unit values and both extremes
    offer_number(0);
    offer_number(1);
    offer_number(-1);
    offer_number(NUM_MAX);
    offer_number(NUM_MIN);
    offer_number(9);
    offer_number(10);
    offer_number(-10);
    await_quiet();

    // Binary: the longest runs, 32 digits plus the sign for the most negative value
    load_base(64'd2, HEX_DIGITS);
    offer_number(NUM_MIN);
    offer_number(-1);
    offer_number(NUM_MAX);
    offer_number(5);
    await_quiet();

    // Full sixteen-symbol base
    load_base(64'd16, HEX_DIGITS);
    offer_number(NUM_MAX);
    offer_number(NUM_MIN);
    offer_number(255);
    offer_number(-256);
    await_quiet();

    // Oversized length saturates at sixteen
    load_base(64'd31, HEX_DIGITS);
    offer_number(12345);
    await_quiet();

    // Lengths below two give nothing
    load_base(64'd0, HEX_DIGITS);
    offer_number(7);
    await_quiet();
    load_base(64'd1, HEX_DIGITS);
    offer_number(7);
    await_quiet();

    // Forbidden active symbols: plus, minus, a zero byte, a repeat
    alphabet = HEX_DIGITS;
    alphabet[8*3 +: 8] = srde_pkg::SYM_PLUS;
    load_base(64'd16, alphabet);
    offer_number(42);
    await_quiet();
    alphabet = HEX_DIGITS;
    alphabet[8*15 +: 8] = srde_pkg::SYM_MINUS;
    load_base(64'd16, alphabet);
    offer_number(-42);
    await_quiet();
    load_base(64'd16, {64'd0, HEX_DIGITS[srde_pkg::DATA_W-1:0]});
    offer_number(42);
    await_quiet();
    load_base(64'd2, {64'd0, 64'hFFFF_FFFF_FFFF_FFFF});
    offer_number(42);
    await_quiet();

    // A plus sign above the active symbols does no harm
    alphabet = HEX_DIGITS;
    alphabet[8*5 +: 8] = srde_pkg::SYM_PLUS;
    load_base(64'd3, alphabet);
    offer_number(-123);
    await_quiet();

    // Random part: a fresh base per phase, every fifth one broken on purpose
    for (int phase = 0; phase < 16; phase++) begin
      flawed = (phase % 5 == 4);
      if ($urandom_range(0, 3) == 0) begin
        radix = $urandom_range(0, 1) ? 16 : 2;
      end else begin
        radix = $urandom_range(2, 16);
      end
      alphabet = draw_alphabet(radix);
      if (flawed) begin
        slot = $urandom_range(0, radix - 1);
        case ($urandom_range(0, 4))
          0: radix = $urandom_range(0, 1);
          1: alphabet[8*slot +: 8] = srde_pkg::SYM_PLUS;
          2: alphabet[8*slot +: 8] = srde_pkg::SYM_MINUS;
          3: alphabet[8*slot +: 8] = srde_pkg::SYM_NUL;
          default: begin
            other = (slot + 1 + $urandom_range(0, radix - 2)) % radix;
            alphabet[8*other +: 8] = alphabet[8*slot +: 8];
          end
        endcase
      end
      // Only the low five bits of the length count; push some sixteens past the top
      length_word = {$urandom, $urandom};
      length_word[srde_pkg::LEN_W-1:0] = (radix == 16 && $urandom_range(0, 1)) ?
                                         srde_pkg::LEN_W'($urandom_range(17, 31)) :
                                         srde_pkg::LEN_W'(radix);
      load_base(length_word, alphabet);

      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 79;
          stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct <= 79;
        end
        default: begin
          send_idle_pct = 23;
          stall_pct <= 23;
        end
      endcase
      // First phase: hold the receiver off while numbers keep coming, so the input stalls
      if (phase == 0) long_hold_req <= 1'b1;

      repeat (flawed ? 8 : 36) offer_number(pick_number());
      await_quiet();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
